// ===== src/fbrc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbrc_pkg - shared definitions for the front-to-back ray compositor
// Fixed-point widths, request and register codes, and the request bundle
// that drives the shared rounding multiplier.
// ----------------------------------------------------------------------------
package fbrc_pkg;

    localparam int CHANNEL_BITS = 16;
    localparam int DEPTH_BITS   = 24;

    // Q1.CH alpha-like values (remaining transparency, cutoff, threshold)
    localparam int ALPHA_W = CHANNEL_BITS + 1;
    // Q2.CH accumulators
    localparam int ACC_W   = CHANNEL_BITS + 2;
    localparam int MUL_Q_W = ALPHA_W;
    localparam int BYTE_W  = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ALPHA_W;

    // request kinds carried in the input tuser
    localparam logic [1:0] REQ_VOLUME = 2'd0;
    localparam logic [1:0] REQ_ISO    = 2'd1;
    localparam logic [1:0] REQ_END    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BG_RED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_GREEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_BLUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd4;

    // one operation for the shared multiplier: q = (a * b + half) >> CH
    typedef struct packed {
        logic                    en;
        logic [CHANNEL_BITS-1:0] a;
        logic [ALPHA_W-1:0]      b;
    } t_mul_req;

endpackage

// ===== src/fbrc_round_mul.sv =====
// ----------------------------------------------------------------------------
// fbrc_round_mul - shared rounding multiplier
// Registers (a * b + half) >> CHANNEL_BITS when enabled, holds otherwise.
// ----------------------------------------------------------------------------
module fbrc_round_mul (
    input  logic                           i_clk,
    input  fbrc_pkg::t_mul_req             i_req,
    output logic [fbrc_pkg::MUL_Q_W-1:0]   o_q
);
    import fbrc_pkg::*;

    localparam int PROD_W = CHANNEL_BITS + ALPHA_W;

    logic [PROD_W-1:0]  prod_rnd;
    logic [MUL_Q_W-1:0] r_q;

    assign prod_rnd = PROD_W'(i_req.a) * PROD_W'(i_req.b)
                    + (PROD_W'(1) << (CHANNEL_BITS - 1));

    // hold the last product while idle so later steps can still read it
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_q <= prod_rnd[PROD_W-1:CHANNEL_BITS];
        end
    end

    assign o_q = r_q;

endmodule

// ===== src/front_to_back_ray_compositor_core.sv =====
// ----------------------------------------------------------------------------
// front_to_back_ray_compositor_core - per-ray front-to-back alpha compositor
// Composited sample: accept + 4 steps, set by the four dependent
// products (ratio, red, green, blue) that share one rounding multiplier.
// Ignored item: taken without leaving S_IDLE. End of ray: accept + 3 steps;
// the pixel item turns valid and ready returns in the same cycle, at once
// while the output register is free, later while it still holds a pixel.
// Reset (i_rst_n low, synchronous): control, configuration and ray state.
// ----------------------------------------------------------------------------
module front_to_back_ray_compositor_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [fbrc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fbrc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // sample stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // from bit 0: sample_red, sample_green, sample_blue, sample_alpha,
    // sample_depth, zero fill to whole bytes
    input  logic [((4*fbrc_pkg::CHANNEL_BITS+fbrc_pkg::DEPTH_BITS+7)/8)*8-1:0]
                                                i_s_tdata,
    // from bit 0: req_type
    input  logic [1:0]                          i_s_tuser,
    // pixel stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // from bit 0: pixel_red, pixel_green, pixel_blue, pixel_alpha,
    // pixel_depth, zero fill to whole bytes
    output logic [((4*fbrc_pkg::BYTE_W+fbrc_pkg::DEPTH_BITS+7)/8)*8-1:0]
                                                o_m_tdata,
    // from bit 0: depth_valid
    output logic                                o_m_tuser
);
    import fbrc_pkg::*;

    localparam int CH         = CHANNEL_BITS;
    localparam int OUT_PIX_W  = 4*BYTE_W + DEPTH_BITS;
    localparam int OUT_DATA_W = ((OUT_PIX_W + 7) / 8) * 8;

    localparam logic [ACC_W-1:0] ONE_ACC  = ACC_W'(1) << CH;
    localparam logic [ACC_W-1:0] ACC_MAX  = {ACC_W{1'b1}};
    localparam logic [ALPHA_W-1:0] ONE_A  = ALPHA_W'(1) << CH;
    localparam logic [ALPHA_W-1:0] HALF_A = ALPHA_W'(1) << (CH - 1);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_RED     = 8'b0000_0010,
        S_GREEN   = 8'b0000_0100,
        S_BLUE    = 8'b0000_1000,
        S_ADDB    = 8'b0001_0000,
        S_END_G   = 8'b0010_0000,
        S_END_B   = 8'b0100_0000,
        S_END_OUT = 8'b1000_0000
    } t_state;

    // Saturating add into a Q2.CH accumulator.
    function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W-1:0] acc,
                                                 input logic [MUL_Q_W-1:0] add);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + (ACC_W+1)'(add);
        return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    endfunction

    // Clamp to 1.0, then round v * 255 to the nearest byte value.
    // v * 255 is (v << 8) - v, so no multiplier is needed here.
    function automatic logic [BYTE_W-1:0] to_byte(input logic [ACC_W:0] v);
        logic [ALPHA_W-1:0]        vc;
        logic [ALPHA_W+BYTE_W-1:0] t;
        vc = (v > (ACC_W+1)'(ONE_A)) ? ONE_A : v[ALPHA_W-1:0];
        t  = {vc, {BYTE_W{1'b0}}} - (ALPHA_W+BYTE_W)'(vc)
           + (ALPHA_W+BYTE_W)'(HALF_A);
        return t[CH+BYTE_W-1:CH];
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [CH-1:0]       r_bg_red, r_bg_green, r_bg_blue;
    logic [ALPHA_W-1:0]  r_cutoff, r_threshold;

    logic [ACC_W-1:0]      r_acc_red, r_acc_green, r_acc_blue, r_acc_alpha;
    logic                  r_depth_latched;
    logic [DEPTH_BITS-1:0] r_latched_depth;

    // captured sample payload and the ratio of the sample at work
    logic [CH-1:0]         r_smp_red, r_smp_green, r_smp_blue;
    logic [DEPTH_BITS-1:0] r_smp_depth;
    logic [CH-1:0]         r_ratio;

    logic [BYTE_W-1:0]     r_byte_red, r_byte_green;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_dvalid;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic [CH-1:0]         in_red, in_green, in_blue, in_alpha;
    logic [DEPTH_BITS-1:0] in_depth;
    logic                  accept, live, sample_go, end_go;
    logic [ALPHA_W-1:0]    remain;

    assign in_red   = i_s_tdata[CH-1:0];
    assign in_green = i_s_tdata[2*CH-1:CH];
    assign in_blue  = i_s_tdata[3*CH-1:2*CH];
    assign in_alpha = i_s_tdata[4*CH-1:3*CH];
    assign in_depth = i_s_tdata[4*CH+DEPTH_BITS-1:4*CH];

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // ray still open: accumulated alpha below the cutoff
    assign live = (r_acc_alpha < ACC_W'(r_cutoff));

    // zero-alpha volume samples drop out; iso hits go through even at zero
    assign sample_go = accept && live
                     && (((i_s_tuser == REQ_VOLUME) && (in_alpha != '0))
                         || (i_s_tuser == REQ_ISO));
    assign end_go    = accept && (i_s_tuser == REQ_END);

    // remaining transparency, Q1.CH; accumulated alpha never exceeds 1.0
    assign remain = (r_acc_alpha >= ONE_ACC) ? '0
                  : ONE_A - r_acc_alpha[ALPHA_W-1:0];

    // ------------------------------------------------------------------
    // Shared multiplier and its operand select
    // ------------------------------------------------------------------
    t_mul_req            mul_req;
    logic [MUL_Q_W-1:0]  mul_q;

    always_comb begin
        mul_req = '0;
        case (r_state)
            S_IDLE: begin
                // ratio for a sample, or the red background term at end of ray
                mul_req.en = sample_go || end_go;
                mul_req.a  = (i_s_tuser == REQ_END) ? r_bg_red : in_alpha;
                mul_req.b  = remain;
            end
            S_RED: begin
                // the product register holds the ratio in this step
                mul_req.en = 1'b1;
                mul_req.a  = r_smp_red;
                mul_req.b  = mul_q;
            end
            S_GREEN: begin
                mul_req.en = 1'b1;
                mul_req.a  = r_smp_green;
                mul_req.b  = ALPHA_W'(r_ratio);
            end
            S_BLUE: begin
                mul_req.en = 1'b1;
                mul_req.a  = r_smp_blue;
                mul_req.b  = ALPHA_W'(r_ratio);
            end
            S_END_G: begin
                mul_req.en = 1'b1;
                mul_req.a  = r_bg_green;
                mul_req.b  = remain;
            end
            S_END_B: begin
                mul_req.en = 1'b1;
                mul_req.a  = r_bg_blue;
                mul_req.b  = remain;
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    fbrc_round_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_q   (mul_q)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic out_load;

    // the pixel leaves S_END_OUT only when the output register is free
    assign out_load = (r_state == S_END_OUT) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (sample_go) begin
                    n_state = S_RED;
                end else if (end_go) begin
                    n_state = S_END_G;
                end
            end
            S_RED:     n_state = S_GREEN;
            S_GREEN:   n_state = S_BLUE;
            S_BLUE:    n_state = S_ADDB;
            S_ADDB:    n_state = S_IDLE;
            S_END_G:   n_state = S_END_B;
            S_END_B:   n_state = S_END_OUT;
            S_END_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_red    <= '0;
            r_bg_green  <= '0;
            r_bg_blue   <= '0;
            r_cutoff    <= ONE_A;
            r_threshold <= HALF_A;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BG_RED:    r_bg_red    <= i_cfg_data[CH-1:0];
                CFG_BG_GREEN:  r_bg_green  <= i_cfg_data[CH-1:0];
                CFG_BG_BLUE:   r_bg_blue   <= i_cfg_data[CH-1:0];
                CFG_CUTOFF:    r_cutoff    <= i_cfg_data;
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default:       ; // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sample capture (payload and ratio)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_smp_red   <= in_red;
            r_smp_green <= in_green;
            r_smp_blue  <= in_blue;
            r_smp_depth <= in_depth;
        end
        if (r_state == S_RED) begin
            r_ratio <= mul_q[CH-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Ray accumulators
    // ------------------------------------------------------------------
    logic [ACC_W:0]     alpha_sum;
    logic [ACC_W-1:0]   n_acc_alpha;

    // ratio never exceeds the remaining transparency, so saturate at 1.0
    assign alpha_sum   = {1'b0, r_acc_alpha} + (ACC_W+1)'(mul_q);
    assign n_acc_alpha = (alpha_sum > (ACC_W+1)'(ONE_ACC)) ? ONE_ACC
                       : alpha_sum[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || out_load) begin
            // clear on reset and after every pixel
            r_acc_red       <= '0;
            r_acc_green     <= '0;
            r_acc_blue      <= '0;
            r_acc_alpha     <= '0;
            r_depth_latched <= 1'b0;
            r_latched_depth <= '0;
        end else begin
            // first isosurface hit latches depth ahead of compositing
            if (sample_go && (i_s_tuser == REQ_ISO) && !r_depth_latched) begin
                r_depth_latched <= 1'b1;
                r_latched_depth <= in_depth;
            end
            case (r_state)
                S_RED: begin
                    r_acc_alpha <= n_acc_alpha;
                    if (!r_depth_latched && (n_acc_alpha >= ACC_W'(r_threshold))) begin
                        r_depth_latched <= 1'b1;
                        r_latched_depth <= r_smp_depth;
                    end
                end
                S_GREEN: r_acc_red   <= sat_acc(r_acc_red, mul_q);
                S_BLUE:  r_acc_green <= sat_acc(r_acc_green, mul_q);
                S_ADDB:  r_acc_blue  <= sat_acc(r_acc_blue, mul_q);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Background blend and byte conversion
    // ------------------------------------------------------------------
    logic [ACC_W:0]    blend_red, blend_green, blend_blue;
    logic [BYTE_W-1:0] byte_blue, byte_alpha;

    assign blend_red   = {1'b0, r_acc_red}   + (ACC_W+1)'(mul_q);
    assign blend_green = {1'b0, r_acc_green} + (ACC_W+1)'(mul_q);
    assign blend_blue  = {1'b0, r_acc_blue}  + (ACC_W+1)'(mul_q);
    assign byte_blue   = to_byte(blend_blue);
    assign byte_alpha  = to_byte({1'b0, r_acc_alpha});

    always_ff @(posedge i_clk) begin
        if (r_state == S_END_G) begin
            r_byte_red <= to_byte(blend_red);
        end
        if (r_state == S_END_B) begin
            r_byte_green <= to_byte(blend_green);
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a pixel until taken
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= OUT_DATA_W'({
                r_depth_latched ? r_latched_depth : {DEPTH_BITS{1'b0}},
                byte_alpha, byte_blue, r_byte_green, r_byte_red});
            r_out_dvalid <= r_depth_latched;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_dvalid;

endmodule
